>>> rtl/patch_post_column_decoder_unit_assert.svh
// assertion macros for the patch post column decoder
// each macro checks a property on the rising edge of clk, held off while rst_n is low
`ifndef PATCH_POST_COLUMN_DECODER_UNIT_ASSERT_SVH
`define PATCH_POST_COLUMN_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define PPCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ppcd assertion failed");

// expression must never be true out of reset
`define PPCD_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ppcd forbidden condition seen");

`else

`define PPCD_ASSERT(lbl, clk, rst_n, prop)
`define PPCD_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/ppcd_pkg.sv
`timescale 1ns / 1ps

package ppcd_pkg;

    // parse phase codes
    localparam logic [2:0] PH_TOP   = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_PAD_A = 3'd2;
    localparam logic [2:0] PH_TEXEL = 3'd3;
    localparam logic [2:0] PH_PAD_B = 3'd4;
    localparam logic [2:0] PH_IDLE  = 3'd5;

    // column terminator in the top row position
    localparam logic [7:0] END_MARK = 8'hff;

    // configuration register indexes
    localparam logic CFG_OFFSET_Y       = 1'b0;
    localparam logic CFG_TEXTURE_HEIGHT = 1'b1;

    localparam logic [15:0] OFFSET_Y_RESET       = 16'd0;
    localparam logic [10:0] TEXTURE_HEIGHT_RESET = 11'd128;

    // one result word
    typedef struct packed {
        logic [15:0] write_address;
        logic [7:0]  texel_value;
        logic        column_end;
    } result_t;

endpackage

>>> rtl/patch_post_column_decoder_unit.sv
`timescale 1ns / 1ps
// flow: an accepted word is held in the input register and parsed into the result register when
//   that register is free or being emptied; the result register drives the texel write channel
// throughput: one stream word per cycle unless the output blocks, set by the single parse stage
// reset: asynchronous, active low; parse phase returns to waiting for a top row,
//   texture_height to 128, patch_offset_y to 0, both pipeline stages empty
`include "patch_post_column_decoder_unit_assert.svh"

module patch_post_column_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    // stream word channel
    input  logic        stream_valid,
    output logic        stream_ready,
    input  logic [7:0]  stream_byte,
    input  logic        column_start,
    input  logic [15:0] column_base,

    // texel write channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] write_address,
    output logic [7:0]  texel_value,
    output logic        column_end
);

    // configuration registers
    logic [15:0] offset_y_reg;
    logic [10:0] height_reg;

    // input register stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic [15:0] in_base_reg;

    // parser state
    logic [2:0]  phase_reg,  phase_next;
    logic [7:0]  top_reg,    top_next;
    logic [7:0]  left_reg,   left_next;
    logic [17:0] row_reg,    row_next;
    logic [15:0] base_reg,   base_next;

    // result register stage
    logic                 res_valid_reg, res_valid_next;
    ppcd_pkg::result_t    res_reg;
    ppcd_pkg::result_t    res_next;
    logic                 produce;

    logic        advance;
    logic [2:0]  eff_phase;
    logic [7:0]  left_dec;
    logic        row_in_window;

    // the parse stage moves when the result register is free or being emptied
    assign advance      = in_valid_reg && (!res_valid_reg || result_ready);
    assign stream_ready = !in_valid_reg || advance;

    // a column start abandons whatever post was in progress
    assign eff_phase = in_start_reg ? ppcd_pkg::PH_TOP : phase_reg;
    assign base_next = in_start_reg ? in_base_reg : base_reg;
    assign left_dec  = left_reg - 8'd1;

    // row must be non negative and below the texture height
    assign row_in_window = !row_reg[17] && (row_reg[16:0] < {6'd0, height_reg});

    always_comb
    begin
        phase_next = eff_phase;
        top_next   = top_reg;
        left_next  = left_reg;
        row_next   = row_reg;
        produce    = 1'b0;
        res_next.write_address = 16'd0;
        res_next.texel_value   = 8'd0;
        res_next.column_end    = 1'b0;
        case (eff_phase)
            ppcd_pkg::PH_TOP:
            begin
                if (in_byte_reg == ppcd_pkg::END_MARK)
                begin
                    // terminator: report end of column, then ignore words until a new start
                    produce             = 1'b1;
                    res_next.column_end = 1'b1;
                    phase_next          = ppcd_pkg::PH_IDLE;
                end
                else
                begin
                    top_next   = in_byte_reg;
                    phase_next = ppcd_pkg::PH_LEN;
                end
            end
            ppcd_pkg::PH_LEN:
            begin
                left_next  = in_byte_reg;
                // first row of the post: offset plus top row, sign extended
                row_next   = {{2{offset_y_reg[15]}}, offset_y_reg} + {10'd0, top_reg};
                phase_next = ppcd_pkg::PH_PAD_A;
            end
            ppcd_pkg::PH_PAD_A:
            begin
                phase_next = (left_reg == 8'd0) ? ppcd_pkg::PH_PAD_B : ppcd_pkg::PH_TEXEL;
            end
            ppcd_pkg::PH_TEXEL:
            begin
                if (row_in_window)
                begin
                    produce                = 1'b1;
                    res_next.write_address = base_next + row_reg[15:0];
                    res_next.texel_value   = in_byte_reg;
                end
                row_next  = row_reg + 18'd1;
                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    phase_next = ppcd_pkg::PH_PAD_B;
                end
            end
            ppcd_pkg::PH_PAD_B:
            begin
                phase_next = ppcd_pkg::PH_TOP;
            end
            default:
            begin
                phase_next = ppcd_pkg::PH_IDLE;
            end
        endcase
    end

    // result valid is set by a parsed word that yields a texel write or the end of column, cleared when taken
    assign res_valid_next = advance ? produce : (res_valid_reg && !result_ready);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_y_reg <= ppcd_pkg::OFFSET_Y_RESET;
            height_reg   <= ppcd_pkg::TEXTURE_HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                ppcd_pkg::CFG_OFFSET_Y:       offset_y_reg <= cfg_data;
                ppcd_pkg::CFG_TEXTURE_HEIGHT: height_reg   <= cfg_data[10:0];
                default:                      height_reg   <= height_reg;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream_ready)
        begin
            in_valid_reg <= stream_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (stream_valid && stream_ready)
        begin
            in_byte_reg  <= stream_byte;
            in_start_reg <= column_start;
            in_base_reg  <= column_base;
        end
    end

    // parser state, updated once per parsed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ppcd_pkg::PH_TOP;
            top_reg   <= 8'd0;
            left_reg  <= 8'd0;
            row_reg   <= 18'd0;
            base_reg  <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            top_reg   <= top_next;
            left_reg  <= left_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign write_address = res_reg.write_address;
    assign texel_value   = res_reg.texel_value;
    assign column_end    = res_reg.column_end;

    // an end of column word carries no write
    `PPCD_ASSERT(a_end_word_empty, clk, rst_n, (result_valid && column_end) |-> (write_address == 16'd0 && texel_value == 8'd0))
    // the input side only stalls when both stages hold a word and the output is blocked
    `PPCD_NEVER(a_stall_cause, clk, rst_n, !stream_ready && !(in_valid_reg && res_valid_reg && !result_ready))
    // a parsed terminator leaves the parser idle
    `PPCD_ASSERT(a_end_goes_idle, clk, rst_n, (advance && produce && res_next.column_end) |=> (phase_reg == ppcd_pkg::PH_IDLE))

endmodule
